>>> rtl/rskt_pkg.sv
`timescale 1ns / 1ps

package rskt_pkg;

  // default sizing
  localparam int TABLE_ENTRIES_DEF = 128;
  localparam int KEY_CHARS_DEF     = 32;

  // field widths
  localparam int KEY_W       = 192;
  localparam int STAMP_W     = 31;
  localparam int IN_TDATA_W  = 232;
  localparam int OUT_TDATA_W = 248;

  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

  // action codes
  localparam logic [1:0] ACT_STORE   = 2'd0;
  localparam logic [1:0] ACT_DROP    = 2'd1;
  localparam logic [1:0] ACT_PRELOAD = 2'd2;

  // status codes
  localparam logic [2:0] STS_INSERTED  = 3'd0;
  localparam logic [2:0] STS_REFRESHED = 3'd1;
  localparam logic [2:0] STS_REMOVED   = 3'd2;
  localparam logic [2:0] STS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STS_FULL      = 3'd4;

  // input transfer layout, last field in the lowest bits
  typedef struct packed {
    logic [5:0]         pad;
    logic signed [31:0] time_value;
    logic [63:0]        key_lo;
    logic [63:0]        key_mid;
    logic [63:0]        key_hi;
    logic [1:0]         action;
  } in_item_t;

  // result transfer layout, last field in the lowest bits
  typedef struct packed {
    logic [5:0]         pad;
    logic [7:0]         entry_count;
    logic [STAMP_W-1:0] stamp;
    logic [63:0]        evicted_key_lo;
    logic [63:0]        evicted_key_mid;
    logic [63:0]        evicted_key_hi;
    logic               evicted;
    logic [6:0]         slot;
    logic [2:0]         status;
  } out_item_t;

  // one table row as held in memory, key is {hi, mid, lo}
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [KEY_W-1:0]   key;
  } entry_t;

endpackage

>>> rtl/rskt_ram.sv
`timescale 1ns / 1ps

module rskt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/recency_stamped_key_table.sv
`timescale 1ns / 1ps

// Keyed table of up to TABLE_ENTRIES rows with 31-bit recency stamps, kept packed
// in arrival order in a single-port-read, single-port-write memory. All work runs
// through one memory read port under a small sequencer, so one item is taken at a
// time and s_axis_tready is low while it is processed. A store scans the table
// once for the key, stopping at the hit position on a refresh; on a miss with a
// full table it scans again for the oldest stamp, shifts the rows above it down
// by one and appends. A drop takes one scan plus the shift when the key is found,
// and a preload appends without a scan. The memory is not cleared after reset;
// only rows below the entry count are ever read. The result sits in an output
// register, so one finished result may wait while the next item runs.
module recency_stamped_key_table #(
  parameter int TABLE_ENTRIES = rskt_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_CHARS     = rskt_pkg::KEY_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // action[1:0], key_hi[65:2], key_mid[129:66], key_lo[193:130], time_value[225:194]
  input  logic [rskt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status[2:0], slot[9:3], evicted[10], evicted_key_hi[74:11],
  // evicted_key_mid[138:75], evicted_key_lo[202:139], stamp[233:203],
  // entry_count[241:234]
  output logic [rskt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import rskt_pkg::*;

  localparam int IDX_W    = $clog2(TABLE_ENTRIES);
  localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_BITS = 6 * KEY_CHARS;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FIND    = 3'd1;
  localparam logic [2:0] S_OLDEST  = 3'd2;
  localparam logic [2:0] S_SHIFT   = 3'd3;
  localparam logic [2:0] S_REFRESH = 3'd4;
  localparam logic [2:0] S_APPEND  = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  in_item_t           in_item;
  out_item_t          out_item;
  entry_t             ram_rdata;
  entry_t             ram_wdata;
  logic               ram_we;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_waddr;

  logic [2:0]         state;
  logic [CNT_W-1:0]   count;
  logic [STAMP_W-1:0] newest_stamp;
  logic [1:0]         action;
  logic [KEY_W-1:0]   key;
  logic [STAMP_W-1:0] reading;
  logic [CNT_W-1:0]   rd_idx;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;
  logic [IDX_W-1:0]   hit_idx;
  logic [STAMP_W-1:0] min_stamp;

  logic [2:0]         res_status;
  logic [6:0]         res_slot;
  logic               res_evicted;
  logic [KEY_W-1:0]   res_evicted_key;
  logic [STAMP_W-1:0] res_stamp;

  logic               issue;
  logic               key_hit;
  logic               scan_done;
  logic [STAMP_W-1:0] stamp_next;
  logic [STAMP_W-1:0] append_stamp;
  logic [STAMP_W-1:0] append_newest;

  assign in_item       = in_item_t'(s_axis_tdata);
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = out_item;

  // table memory
  rskt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // scan pipeline control: one read issued per cycle, compared when it returns from the registered read port
  assign issue     = (rd_idx < count);
  assign key_hit   = pend && (ram_rdata.key == key);
  assign scan_done = !pend && !issue;
  assign ram_re    = issue && (state == S_FIND || state == S_OLDEST || state == S_SHIFT);

  // store stamp: reading, or one past the newest, saturating; a preload keeps the reading
  always_comb begin
    if (reading <= newest_stamp) begin
      stamp_next = (newest_stamp == STAMP_MAX) ? STAMP_MAX : newest_stamp + 1'b1;
    end else begin
      stamp_next = reading;
    end
    if (action == ACT_PRELOAD) begin
      append_stamp  = reading;
      append_newest = (reading > newest_stamp) ? reading : newest_stamp;
    end else begin
      append_stamp  = stamp_next;
      append_newest = stamp_next;
    end
  end

  // memory write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = '{stamp: append_stamp, key: key};
    unique case (state)
      S_SHIFT: begin
        ram_we    = pend;
        ram_waddr = pend_idx - 1'b1;
        ram_wdata = ram_rdata;
      end
      S_REFRESH: begin
        ram_we    = 1'b1;
        ram_waddr = hit_idx;
        ram_wdata = '{stamp: stamp_next, key: key};
      end
      S_APPEND: begin
        ram_we    = 1'b1;
      end
      default: begin
        ram_we    = 1'b0;
      end
    endcase
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      newest_stamp  <= '0;
      pend          <= 1'b0;
      rd_idx        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // output register handshake
      if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      // scan issue, shared by all scanning states; a hit or a finished pass
      // loads the start of the next pass
      if (state == S_FIND || state == S_OLDEST || state == S_SHIFT) begin
        pend_idx <= rd_idx[IDX_W-1:0];
        if (state == S_FIND && key_hit) begin
          pend   <= 1'b0;
          rd_idx <= CNT_W'(pend_idx) + CNT_W'(1);
        end else if (state == S_OLDEST && scan_done) begin
          pend   <= 1'b0;
          rd_idx <= CNT_W'(hit_idx) + CNT_W'(1);
        end else if (scan_done) begin
          pend   <= 1'b0;
          rd_idx <= '0;
        end else begin
          pend <= issue;
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            action          <= in_item.action;
            key             <= {in_item.key_hi, in_item.key_mid, in_item.key_lo} & KEY_MASK;
            reading         <= in_item.time_value[31] ? '0 : in_item.time_value[30:0];
            rd_idx          <= '0;
            pend            <= 1'b0;
            res_status      <= (in_item.action == ACT_PRELOAD && count == FULL_COUNT) ?
                               STS_FULL : STS_NOT_FOUND;
            res_slot        <= '0;
            res_evicted     <= 1'b0;
            res_evicted_key <= '0;
            res_stamp       <= '0;
            unique case (in_item.action) inside
              ACT_STORE, ACT_DROP: begin
                state <= S_FIND;
              end
              ACT_PRELOAD: begin
                if (count == FULL_COUNT) begin
                  state <= S_DONE;
                end else begin
                  state <= S_APPEND;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        // look for the key among the valid rows
        S_FIND: begin
          if (key_hit) begin
            hit_idx <= pend_idx;
            if (action == ACT_STORE) begin
              state <= S_REFRESH;
            end else begin
              state <= S_SHIFT;
            end
          end else if (scan_done) begin
            if (action == ACT_DROP) begin
              state <= S_DONE;
            end else if (count == FULL_COUNT) begin
              state <= S_OLDEST;
            end else begin
              state <= S_APPEND;
            end
          end
        end

        // smallest stamp, lowest position on a tie
        S_OLDEST: begin
          if (pend && (pend_idx == '0 || ram_rdata.stamp < min_stamp)) begin
            min_stamp       <= ram_rdata.stamp;
            hit_idx         <= pend_idx;
            res_evicted_key <= ram_rdata.key;
          end
          if (scan_done) begin
            res_evicted <= 1'b1;
            state       <= S_SHIFT;
          end
        end

        // move rows above the gap down by one
        S_SHIFT: begin
          if (scan_done) begin
            count <= count - 1'b1;
            if (action == ACT_STORE) begin
              state <= S_APPEND;
            end else begin
              res_status <= STS_REMOVED;
              res_slot   <= 7'(hit_idx);
              state      <= S_DONE;
            end
          end
        end

        S_REFRESH: begin
          newest_stamp <= stamp_next;
          res_status   <= STS_REFRESHED;
          res_slot     <= 7'(hit_idx);
          res_stamp    <= stamp_next;
          state        <= S_DONE;
        end

        S_APPEND: begin
          count        <= count + 1'b1;
          newest_stamp <= append_newest;
          res_status   <= STS_INSERTED;
          res_slot     <= 7'(count);
          res_stamp    <= append_stamp;
          state        <= S_DONE;
        end

        // hand the result to the output register once it is free
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      out_item.pad             <= '0;
      out_item.status          <= res_status;
      out_item.slot            <= res_slot;
      out_item.evicted         <= res_evicted;
      out_item.evicted_key_hi  <= res_evicted_key[191:128];
      out_item.evicted_key_mid <= res_evicted_key[127:64];
      out_item.evicted_key_lo  <= res_evicted_key[63:0];
      out_item.stamp           <= res_stamp;
      out_item.entry_count     <= 8'(count);
    end
  end

`ifndef SYNTHESIS
  // entry count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count beyond table size");

  // writes land only on a valid row or the next free one
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (CNT_W'(ram_waddr) <= count && CNT_W'(ram_waddr) < FULL_COUNT))
    else $error("table write outside packed range");

  // newest stamp never moves backward
  a_newest_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> newest_stamp >= $past(newest_stamp))
    else $error("newest stamp decreased");

  // count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count) || count == $past(count) + 1'b1 ||
              count + 1'b1 == $past(count)))
    else $error("entry count jumped");
`endif

endmodule

>>> tb/tb_recency_stamped_key_table.sv
`timescale 1ns / 1ps

module tb_recency_stamped_key_table;
  import rskt_pkg::*;

  localparam int TABLE_DEPTH = TABLE_ENTRIES_DEF;
  localparam int POOL_SIZE   = 160;

  // action 3 is not decoded by the block
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_STINGY} rx_mode_t;

  // keeps a shadow of the table and the results it should produce
  class stamp_table_scoreboard;
    logic [KEY_W-1:0]   row_key [TABLE_DEPTH];
    logic [STAMP_W-1:0] row_stamp [TABLE_DEPTH];
    int                 used;
    logic [STAMP_W-1:0] newest_stamp;
    out_item_t          expected_results [$];
    int                 errors;

    function new();
      used = 0;
      newest_stamp = '0;
      errors = 0;
    endfunction

    function int find_row(logic [KEY_W-1:0] key);
      for (int i = 0; i < used; i++) begin
        if (row_key[i] == key) return i;
      end
      return -1;
    endfunction

    // close the gap left by a removed row
    function void remove_row(int at);
      for (int i = at; i + 1 < used; i++) begin
        row_key[i]   = row_key[i + 1];
        row_stamp[i] = row_stamp[i + 1];
      end
      used--;
    endfunction

    // store stamp: at least one past the newest, saturating
    function logic [STAMP_W-1:0] advance_stamp(logic [STAMP_W-1:0] reading);
      if (reading <= newest_stamp)
        reading = (newest_stamp == STAMP_MAX) ? STAMP_MAX : newest_stamp + 1'b1;
      newest_stamp = reading;
      return reading;
    endfunction

    function logic [KEY_W-1:0] pick_stored();
      return row_key[$urandom_range(0, used - 1)];
    endfunction

    function out_item_t predict_result(in_item_t req);
      out_item_t          r;
      logic [KEY_W-1:0]   key;
      logic [STAMP_W-1:0] reading;
      int                 at;
      int                 oldest;
      r = '0;
      r.status = STS_NOT_FOUND;
      key = {req.key_hi, req.key_mid, req.key_lo};
      reading = req.time_value[31] ? '0 : req.time_value[STAMP_W-1:0];
      case (req.action)
        ACT_STORE: begin
          at = find_row(key);
          if (at >= 0) begin
            r.stamp = advance_stamp(reading);
            row_stamp[at] = r.stamp;
            r.status = STS_REFRESHED;
            r.slot = at[6:0];
          end else begin
            // full table: evict the smallest stamp, lowest slot on a tie
            if (used >= TABLE_DEPTH) begin
              oldest = 0;
              for (int i = 1; i < used; i++) begin
                if (row_stamp[i] < row_stamp[oldest]) oldest = i;
              end
              r.evicted = 1'b1;
              {r.evicted_key_hi, r.evicted_key_mid, r.evicted_key_lo} = row_key[oldest];
              remove_row(oldest);
            end
            r.stamp = advance_stamp(reading);
            row_key[used] = key;
            row_stamp[used] = r.stamp;
            r.status = STS_INSERTED;
            r.slot = used[6:0];
            used++;
          end
        end
        ACT_DROP: begin
          at = find_row(key);
          if (at >= 0) begin
            remove_row(at);
            r.status = STS_REMOVED;
            r.slot = at[6:0];
          end
        end
        ACT_PRELOAD: begin
          if (used >= TABLE_DEPTH) begin
            r.status = STS_FULL;
          end else begin
            row_key[used] = key;
            row_stamp[used] = reading;
            if (reading > newest_stamp) newest_stamp = reading;
            r.stamp = reading;
            r.status = STS_INSERTED;
            r.slot = used[6:0];
            used++;
          end
        end
        default: ;
      endcase
      r.entry_count = used[7:0];
      return r;
    endfunction

    function void note_request(in_item_t req);
      expected_results.push_back(predict_result(req));
    endfunction

    function int compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      int        bad;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: status %0d slot %0d",
               got.status, got.slot);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      bad = 0;
      bad += compare_field("status", want.status, got.status);
      bad += compare_field("slot", want.slot, got.slot);
      bad += compare_field("evicted", want.evicted, got.evicted);
      bad += compare_field("evicted_key_hi", want.evicted_key_hi, got.evicted_key_hi);
      bad += compare_field("evicted_key_mid", want.evicted_key_mid, got.evicted_key_mid);
      bad += compare_field("evicted_key_lo", want.evicted_key_lo, got.evicted_key_lo);
      bad += compare_field("stamp", want.stamp, got.stamp);
      bad += compare_field("entry_count", want.entry_count, got.entry_count);
      if (bad != 0) errors++;
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  stamp_table_scoreboard board = new();
  logic [KEY_W-1:0]      key_pool [POOL_SIZE];
  int                    burst_left = 0;
  rx_mode_t              rx_mode = RX_OPEN;
  int                    rx_left = 100;

  recency_stamped_key_table DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver backpressure, switching between a few patterns
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     m_axis_tready <= 1'b1;
      RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: m_axis_tready <= (rx_left[1:0] == 2'b00);
      default:     m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // result checking on each output transfer
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(out_item_t'(m_axis_tdata));
  end

  function automatic logic [KEY_W-1:0] fresh_key();
    return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  function automatic in_item_t make_req(logic [1:0] action, logic [KEY_W-1:0] key,
                                        logic signed [31:0] reading);
    in_item_t req;
    req = '0;
    req.action = action;
    {req.key_hi, req.key_mid, req.key_lo} = key;
    req.time_value = reading;
    return req;
  endfunction

  // clock readings around the newest stamp, with negatives and wild values mixed in
  function automatic logic signed [31:0] pick_time();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return $urandom() | 32'h8000_0000;
    if (roll < 18) return '0;
    if (roll < 23) return $urandom();
    if (roll < 60) return {1'b0, board.newest_stamp} + $urandom_range(1, 50);
    return $urandom_range(0, board.newest_stamp);
  endfunction

  function automatic in_item_t random_request(mix_t mix);
    in_item_t    req;
    int unsigned roll;
    logic        want_stored;
    req = make_req(ACT_STORE, key_pool[$urandom_range(0, POOL_SIZE - 1)], pick_time());
    roll = $urandom_range(0, 99);
    want_stored = 1'b0;
    case (mix)
      MIX_FILL: begin
        if (roll < 45) {req.key_hi, req.key_mid, req.key_lo} = fresh_key();
        else if (roll < 65) ;
        else if (roll < 85) req.action = ACT_PRELOAD;
        else if (roll < 95) begin
          req.action = ACT_DROP;
          want_stored = 1'b1;
        end else req.action = ACT_UNUSED;
      end
      MIX_CHURN: begin
        if (roll < 25) want_stored = 1'b1;
        else if (roll < 55) ;
        else if (roll < 65) {req.key_hi, req.key_mid, req.key_lo} = fresh_key();
        else if (roll < 80) begin
          req.action = ACT_DROP;
          want_stored = 1'b1;
        end else if (roll < 85) req.action = ACT_DROP;
        else if (roll < 95) req.action = ACT_PRELOAD;
        else req.action = ACT_UNUSED;
      end
      default: begin
        if (roll < 55) begin
          req.action = ACT_DROP;
          want_stored = 1'b1;
        end else if (roll < 65) begin
          req.action = ACT_DROP;
          {req.key_hi, req.key_mid, req.key_lo} = fresh_key();
        end else if (roll < 85) ;
        else if (roll < 95) req.action = ACT_PRELOAD;
        else req.action = ACT_UNUSED;
      end
    endcase
    if (want_stored && board.used > 0)
      {req.key_hi, req.key_mid, req.key_lo} = board.pick_stored();
    return req;
  endfunction

  // one input transfer, then either stay in the burst or idle for a while
  task automatic send(input in_item_t req);
    s_axis_tdata  <= req;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_request(req);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  initial begin
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
    mix_t             mix;
    int               seg_left;

    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = fresh_key();
    key_a = fresh_key();
    key_b = fresh_key();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, refresh rules, duplicates, gap closing
    send(make_req(ACT_DROP, '0, 32'sd0));
    send(make_req(ACT_UNUSED, '1, 32'sd7));
    send(make_req(ACT_STORE, '1, -32'sd1));
    send(make_req(ACT_STORE, '0, 32'sd0));
    send(make_req(ACT_STORE, '1, 32'sd100));
    send(make_req(ACT_STORE, key_a, 32'sd50));
    send(make_req(ACT_PRELOAD, key_b, -32'sd5));
    send(make_req(ACT_PRELOAD, key_a, 32'sd1000));
    send(make_req(ACT_STORE, key_a, 32'sd2000));
    send(make_req(ACT_DROP, key_a, 32'sd0));
    send(make_req(ACT_DROP, key_a, 32'sd0));
    send(make_req(ACT_DROP, key_a, 32'sd0));
    send(make_req(ACT_STORE, key_b, 32'sh8000_0000));
    send(make_req(ACT_DROP, '0, 32'sd0));
    send(make_req(ACT_PRELOAD, key_a, 32'sh4000_0000));
    send(make_req(ACT_STORE, fresh_key(), 32'sh3FFF_FFFF));
    send(make_req(ACT_PRELOAD, fresh_key(), 32'sd0));
    send(make_req(ACT_PRELOAD, fresh_key(), 32'sd0));
    send(make_req(ACT_UNUSED, key_b, -32'sd1));
    send(make_req(ACT_DROP, '1, 32'sd0));

    // random: segments of fill, churn and drain around a shared key pool
    mix = MIX_FILL;
    seg_left = 180;
    for (int n = 0; n < 1500; n++) begin
      if (seg_left == 0) begin
        case ($urandom_range(0, 9))
          0, 1:    mix = MIX_FILL;
          2, 3:    mix = MIX_DRAIN;
          default: mix = MIX_CHURN;
        endcase
        seg_left = $urandom_range(40, 200);
      end
      seg_left--;
      send(random_request(mix));
    end

    // stamp saturation, then evictions among saturated stamps
    if (board.used >= TABLE_DEPTH) send(make_req(ACT_DROP, board.pick_stored(), 32'sd0));
    send(make_req(ACT_PRELOAD, fresh_key(), 32'sh7FFF_FFFF));
    send(make_req(ACT_STORE, fresh_key(), 32'sd5));
    repeat (30) send(random_request(MIX_CHURN));
    s_axis_tvalid <= 1'b0;

    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/rskt_pkg.sv
rtl/rskt_ram.sv
rtl/recency_stamped_key_table.sv
tb/tb_recency_stamped_key_table.sv
